// ----- hdl/tmlf_pkg.sv -----
// Shared constants, register map and configuration type of the trimmed-mean level filter.
`timescale 1ns / 1ps

package tmlf_pkg;

  // Default set size and trim per end
  localparam int unsigned SAMPLES_DEF = 8;
  localparam int unsigned TRIM_DEF    = 2;

  // Field widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned GAIN_W   = 10;
  localparam int unsigned LEVEL_W  = 20;
  localparam int unsigned FRAC_W   = 8;

  // Divider: dividend covers gain * level, divisor covers the peak
  localparam int unsigned DIV_N = GAIN_W + LEVEL_W;
  localparam int unsigned DIV_D = SAMPLE_W;

  // APB register map
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam logic [2:0] REG_CLAMP = 3'd0;
  localparam logic [2:0] REG_NORM  = 3'd1;
  localparam logic [2:0] REG_GAIN  = 3'd2;
  localparam logic [2:0] REG_PEAK  = 3'd3;
  localparam logic [2:0] REG_FLOOR = 3'd4;

  // Register reset values
  localparam logic [SAMPLE_W-1:0] CLAMP_RST = 12'd500;
  localparam logic [GAIN_W-1:0]   GAIN_RST  = 10'd100;
  localparam logic [SAMPLE_W-1:0] PEAK_RST  = 12'd100;
  localparam logic [LEVEL_W-1:0]  FLOOR_RST = 20'd256;

  // Peak above this forces normalization
  localparam logic [SAMPLE_W-1:0] NORM_PEAK_THR = 12'd100;
  localparam logic [LEVEL_W-1:0]  LEVEL_MAX     = {LEVEL_W{1'b1}};

  typedef struct packed {
    logic [SAMPLE_W-1:0] clamp_limit;
    logic                norm_enable;
    logic [GAIN_W-1:0]   norm_gain;
    logic [SAMPLE_W-1:0] peak_level;
    logic [LEVEL_W-1:0]  floor_level;
  } cfg_t;

endpackage

// ----- hdl/tmlf_regs.sv -----
// APB configuration registers of the trimmed-mean level filter.
`timescale 1ns / 1ps

module tmlf_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tmlf_pkg::ADDR_W-1:0]       paddr,
  input  logic [tmlf_pkg::DATA_W-1:0]       pwdata,
  output logic [tmlf_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  output tmlf_pkg::cfg_t                    cfg_o
);

  tmlf_pkg::cfg_t cfg_q;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[tmlf_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // Write the addressed register, mask to its width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clamp_limit <= tmlf_pkg::CLAMP_RST;
      cfg_q.norm_enable <= 1'b0;
      cfg_q.norm_gain   <= tmlf_pkg::GAIN_RST;
      cfg_q.peak_level  <= tmlf_pkg::PEAK_RST;
      cfg_q.floor_level <= tmlf_pkg::FLOOR_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        tmlf_pkg::REG_CLAMP: cfg_q.clamp_limit <= pwdata[tmlf_pkg::SAMPLE_W-1:0];
        tmlf_pkg::REG_NORM:  cfg_q.norm_enable <= pwdata[0];
        tmlf_pkg::REG_GAIN:  cfg_q.norm_gain   <= pwdata[tmlf_pkg::GAIN_W-1:0];
        tmlf_pkg::REG_PEAK:  cfg_q.peak_level  <= pwdata[tmlf_pkg::SAMPLE_W-1:0];
        tmlf_pkg::REG_FLOOR: cfg_q.floor_level <= pwdata[tmlf_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      tmlf_pkg::REG_CLAMP: prdata = tmlf_pkg::DATA_W'(cfg_q.clamp_limit);
      tmlf_pkg::REG_NORM:  prdata = tmlf_pkg::DATA_W'(cfg_q.norm_enable);
      tmlf_pkg::REG_GAIN:  prdata = tmlf_pkg::DATA_W'(cfg_q.norm_gain);
      tmlf_pkg::REG_PEAK:  prdata = tmlf_pkg::DATA_W'(cfg_q.peak_level);
      tmlf_pkg::REG_FLOOR: prdata = tmlf_pkg::DATA_W'(cfg_q.floor_level);
      default:             prdata = '0;
    endcase
  end

endmodule

// ----- hdl/tmlf_store.sv -----
// Sample memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module tmlf_store #(
  parameter int unsigned DEPTH = tmlf_pkg::SAMPLES_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [tmlf_pkg::SAMPLE_W-1:0] wdata_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic [tmlf_pkg::SAMPLE_W-1:0] rdata_o
);

  logic [tmlf_pkg::SAMPLE_W-1:0] mem_q [DEPTH];
  logic [tmlf_pkg::SAMPLE_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/tmlf_div.sv -----
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module tmlf_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tmlf_pkg::DIV_N-1:0]  dividend_i,
  input  logic [tmlf_pkg::DIV_D-1:0]  divisor_i,
  output logic                        done_o,
  output logic [tmlf_pkg::DIV_N-1:0]  quotient_o
);

  localparam int unsigned CW = $clog2(tmlf_pkg::DIV_N);

  logic [tmlf_pkg::DIV_D-1:0] dvs_q;
  logic [tmlf_pkg::DIV_D-1:0] rem_q, rem_d;
  logic [tmlf_pkg::DIV_N-1:0] quo_q, quo_d;
  logic [CW-1:0]              cnt_q;
  logic                       run_q, done_q;
  logic [tmlf_pkg::DIV_D:0]   trial;
  logic                       fits;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {rem_q, quo_q[tmlf_pkg::DIV_N-1]};
    fits  = trial >= {1'b0, dvs_q};
    rem_d = fits ? tmlf_pkg::DIV_D'(trial - {1'b0, dvs_q}) : trial[tmlf_pkg::DIV_D-1:0];
    quo_d = {quo_q[tmlf_pkg::DIV_N-2:0], fits};
  end

  // Control: load on start, step until the last bit, then pulse done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(tmlf_pkg::DIV_N - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- hdl/trimmed_mean_level_filter.sv -----
// Top level of the trimmed-mean level filter: sorted insertion, trimmed sum and normalization.
`timescale 1ns / 1ps

// Usage
//   Input: drive sample_i and raise start; the item is taken at a clock edge where
//   start is high and busy is low. Each sample is clamped to clamp_limit and inserted
//   in ascending order into the sample memory, moving one larger entry up per cycle.
//   The first item of a set is written straight in; any other reads, moves the larger
//   entries up (at most SAMPLES-1) and writes the item, bounded by the single memory port pair.
//   The item that completes a set then sums the kept entries (one memory read per
//   cycle, KEPT = SAMPLES-2*TRIM reads, TRIM capped at (SAMPLES-1)/2), takes the mean by
//   reciprocal multiplication and, when normalization applies, multiplies by
//   norm_gain and divides by peak_level on a bit-serial divider. The result
//   follows from ST_SUM, ST_SEND and ST_MEAN, with ST_MUL and ST_NORM when
//   normalizing, and is presented in ST_OUT.
//   Output: done_o is high for one cycle with level_o and floored_level_o valid; the
//   receiver takes it in that cycle and cannot stall the block.
//   Configuration: APB writes, pready always high, registers at byte offsets 4*i.
//   Reset clears the sample count and loads the register defaults; the memory
//   needs no clearing since every entry is written before it is read.

module trimmed_mean_level_filter #(
  parameter int unsigned SAMPLES = tmlf_pkg::SAMPLES_DEF,
  parameter int unsigned TRIM    = tmlf_pkg::TRIM_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [tmlf_pkg::SAMPLE_W-1:0] sample_i,
  output logic                          done_o,
  output logic [tmlf_pkg::LEVEL_W-1:0]  level_o,
  output logic [tmlf_pkg::LEVEL_W-1:0]  floored_level_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tmlf_pkg::ADDR_W-1:0]   paddr,
  input  logic [tmlf_pkg::DATA_W-1:0]   pwdata,
  output logic [tmlf_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned IDX_W    = $clog2(SAMPLES);
  localparam int unsigned CNT_W    = $clog2(SAMPLES + 1);
  localparam int unsigned SUM_W    = tmlf_pkg::SAMPLE_W + CNT_W;
  localparam int unsigned TRIM_LIM = (SAMPLES - 1) / 2;
  localparam int unsigned TRIM_EFF = (TRIM > TRIM_LIM) ? TRIM_LIM : TRIM;
  localparam int unsigned KEPT     = SAMPLES - 2 * TRIM_EFF;
  localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(TRIM_EFF);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SAMPLES - 1 - TRIM_EFF);
  localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(SAMPLES - 1);

  // Mean by reciprocal: floor(x / KEPT) = (x * ceil(2^SH / KEPT)) >> SH for x < 2^MEAN_W
  localparam int unsigned      MEAN_W     = SUM_W + tmlf_pkg::FRAC_W;
  localparam int unsigned      KEPT_LOG   = $clog2(KEPT);
  localparam int unsigned      MEAN_SH    = MEAN_W + KEPT_LOG;
  localparam int unsigned      RECIP_W    = MEAN_W + 1;
  localparam int unsigned      PROD_W     = MEAN_W + RECIP_W;
  localparam longint unsigned  RECIP_V    = ((64'd1 << MEAN_SH) + KEPT - 1) / KEPT;
  localparam logic [RECIP_W-1:0] MEAN_RECIP = RECIP_W'(RECIP_V);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CMP   = 4'd1;
  localparam logic [3:0] ST_PLACE = 4'd2;
  localparam logic [3:0] ST_SUM   = 4'd3;
  localparam logic [3:0] ST_SEND  = 4'd4;
  localparam logic [3:0] ST_MEAN  = 4'd5;
  localparam logic [3:0] ST_MUL   = 4'd6;
  localparam logic [3:0] ST_NORM  = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  tmlf_pkg::cfg_t cfg;

  logic [3:0]                    state_q, state_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [IDX_W-1:0]              pos_q, pos_d;
  logic [tmlf_pkg::SAMPLE_W-1:0] samp_q, samp_d;
  logic [SUM_W-1:0]              sum_q, sum_d;
  logic                          rd_pend_q, rd_pend_d;
  logic [tmlf_pkg::LEVEL_W-1:0]  lvl_q, lvl_d;
  logic [tmlf_pkg::DIV_N-1:0]    prod_q, prod_d;

  logic                          mem_we;
  logic [IDX_W-1:0]              mem_waddr, mem_raddr;
  logic [tmlf_pkg::SAMPLE_W-1:0] mem_wdata, mem_rdata;

  logic                          div_start, div_done;
  logic [tmlf_pkg::DIV_N-1:0]    div_dividend, div_quotient;
  logic [tmlf_pkg::DIV_D-1:0]    div_divisor;

  logic                          ins_done;
  logic                          norm_on;
  logic [tmlf_pkg::SAMPLE_W-1:0] clamped;
  logic [MEAN_W-1:0]             mean_num;
  logic [PROD_W-1:0]             mean_prod;

  tmlf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tmlf_store #(
    .DEPTH (SAMPLES),
    .AW    (IDX_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  tmlf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  assign clamped = (sample_i > cfg.clamp_limit) ? cfg.clamp_limit : sample_i;
  assign norm_on = cfg.norm_enable || (cfg.peak_level > tmlf_pkg::NORM_PEAK_THR);

  // Scale the trimmed sum to 8 fraction bits and divide by the kept count
  assign mean_num  = {sum_q, {tmlf_pkg::FRAC_W{1'b0}}};
  assign mean_prod = PROD_W'(mean_num) * PROD_W'(MEAN_RECIP);

  // Sequence insertion, summing, the mean and the peak divide
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    samp_d       = samp_q;
    sum_d        = sum_q;
    rd_pend_d    = 1'b0;
    lvl_d        = lvl_q;
    prod_d       = prod_q;
    mem_we       = 1'b0;
    mem_waddr    = pos_q;
    mem_wdata    = samp_q;
    mem_raddr    = pos_q;
    div_start    = 1'b0;
    div_dividend = prod_q;
    div_divisor  = (cfg.peak_level == '0) ? tmlf_pkg::DIV_D'(1) : cfg.peak_level;
    ins_done     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          samp_d = clamped;
          if (cnt_q == '0) begin
            // first entry of a set goes straight in
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = clamped;
            ins_done  = 1'b1;
          end else begin
            pos_d     = cnt_q[IDX_W-1:0];
            mem_raddr = cnt_q[IDX_W-1:0] - IDX_W'(1);
            state_d   = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        // move a larger entry up, or drop the item into the hole
        mem_we = 1'b1;
        if (mem_rdata > samp_q) begin
          mem_wdata = mem_rdata;
          pos_d     = pos_q - IDX_W'(1);
          mem_raddr = pos_q - IDX_W'(2);
          if (pos_q == IDX_W'(1)) begin
            state_d = ST_PLACE;
          end
        end else begin
          ins_done = 1'b1;
        end
      end
      ST_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        ins_done  = 1'b1;
      end
      ST_SUM: begin
        // read kept entries in turn, accumulate each in the cycle after its read
        rd_pend_d = 1'b1;
        if (rd_pend_q) begin
          sum_d = sum_q + SUM_W'(mem_rdata);
        end
        if (pos_q == LAST_IDX) begin
          state_d = ST_SEND;
        end else begin
          pos_d = pos_q + IDX_W'(1);
        end
      end
      ST_SEND: begin
        sum_d   = sum_q + SUM_W'(mem_rdata);
        state_d = ST_MEAN;
      end
      ST_MEAN: begin
        // take the mean, then normalize or finish
        lvl_d   = mean_prod[MEAN_SH +: tmlf_pkg::LEVEL_W];
        state_d = norm_on ? ST_MUL : ST_OUT;
      end
      ST_MUL: begin
        prod_d  = tmlf_pkg::DIV_N'(cfg.norm_gain) * tmlf_pkg::DIV_N'(lvl_q);
        state_d = ST_NORM;
      end
      ST_NORM: begin
        // start the peak divide once, then saturate its quotient
        if (!rd_pend_q) begin
          div_start    = 1'b1;
          div_dividend = prod_q;
          div_divisor  = (cfg.peak_level == '0) ? tmlf_pkg::DIV_D'(1) : cfg.peak_level;
        end
        rd_pend_d = 1'b1;
        if (div_done) begin
          rd_pend_d = 1'b0;
          if (|div_quotient[tmlf_pkg::DIV_N-1:tmlf_pkg::LEVEL_W]) begin
            lvl_d = tmlf_pkg::LEVEL_MAX;
          end else begin
            lvl_d = div_quotient[tmlf_pkg::LEVEL_W-1:0];
          end
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Count the stored item; a full set starts the trimmed sum
    if (ins_done) begin
      if (cnt_q == LAST_CNT) begin
        cnt_d     = '0;
        pos_d     = FIRST_IDX;
        sum_d     = '0;
        rd_pend_d = 1'b0;
        state_d   = ST_SUM;
      end else begin
        cnt_d   = cnt_q + CNT_W'(1);
        state_d = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    samp_q <= samp_d;
    sum_q  <= sum_d;
    lvl_q  <= lvl_d;
    prod_q <= prod_d;
  end

  // Present the result for one cycle
  assign busy            = (state_q != ST_IDLE);
  assign done_o          = (state_q == ST_OUT);
  assign level_o         = lvl_q;
  assign floored_level_o = (lvl_q < cfg.floor_level) ? cfg.floor_level : lvl_q;

endmodule
